[hw/rtl/ofsp_pkg.sv]
package ofsp_pkg;

    // Internal index and counter width.
    localparam int INDEX_BITS = 24;
    // Width of the reference and face number fields on the result channel.
    localparam int OUT_W      = 24;
    // Accumulator width for the times-ten step before saturation.
    localparam int WIDE_W     = INDEX_BITS + 4;

    localparam logic [INDEX_BITS-1:0] IDX_MAX = {INDEX_BITS{1'b1}};

    // Event queue between front and back.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Characters
    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_SP    = 8'd32;
    localparam logic [7:0] CH_HASH  = 8'd35;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_SLASH = 8'd47;
    localparam logic [7:0] CH_0     = 8'd48;
    localparam logic [7:0] CH_9     = 8'd57;
    localparam logic [7:0] CH_F     = 8'd102;
    localparam logic [7:0] CH_N     = 8'd110;
    localparam logic [7:0] CH_T     = 8'd116;
    localparam logic [7:0] CH_V     = 8'd118;

    // Record kinds on the result channel
    localparam logic REC_CORNER = 1'b0;
    localparam logic REC_END    = 1'b1;

    typedef enum logic [2:0] {
        K_NONE,
        K_V,
        K_VT,
        K_VN,
        K_F,
        K_COMMENT,
        K_OTHER
    } t_kind;

    typedef enum logic [1:0] {
        P_START,
        P_AFTER_V,
        P_AFTER_F,
        P_DONE
    } t_pend;

    typedef enum logic [1:0] {
        PH_START,
        PH_DIGITS,
        PH_STOP
    } t_phase;

    // One queued event: an optional corner and/or a face-end marker.
    typedef struct packed {
        logic             has_corner;
        logic             is_end;
        logic [OUT_W-1:0] face;
        logic [OUT_W-1:0] vref;
        logic [OUT_W-1:0] tref;
        logic [OUT_W-1:0] nref;
    } t_event;

    typedef struct packed {
        logic   push;
        t_event data;
    } t_push;

endpackage

[hw/rtl/ofsp_front.sv]
module ofsp_front
    import ofsp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic [7:0] i_text_byte,
    output t_push      o_push
);

    t_kind                 r_kind,  n_kind;
    t_pend                 r_pend,  n_pend;
    t_phase                r_ph,    n_ph;
    logic                  r_neg,   n_neg;
    logic                  r_tok,   n_tok;
    logic [1:0]            r_slot,  n_slot;
    logic [INDEX_BITS-1:0] r_accum, n_accum;
    logic [INDEX_BITS-1:0] r_held_v, n_held_v;
    logic [INDEX_BITS-1:0] r_held_t, n_held_t;
    logic [INDEX_BITS-1:0] r_vcnt, n_vcnt;
    logic [INDEX_BITS-1:0] r_tcnt, n_tcnt;
    logic [INDEX_BITS-1:0] r_ncnt, n_ncnt;
    logic [INDEX_BITS-1:0] r_face, n_face;

    logic                  w_nl, w_blank, w_digit, w_sign;
    logic                  w_close, w_end, w_keep;
    logic [INDEX_BITS-1:0] w_count, w_res;
    logic [INDEX_BITS-1:0] w_cv, w_ct, w_cn;
    logic [WIDE_W-1:0]     w_wide;

    assign w_nl    = (i_text_byte == CH_NL);
    assign w_blank = (i_text_byte == CH_SP) || (i_text_byte == CH_TAB);
    assign w_digit = (i_text_byte >= CH_0) && (i_text_byte <= CH_9);
    assign w_sign  = (i_text_byte == CH_PLUS) || (i_text_byte == CH_MINUS);

    // One resolver, count picked by the subfield being closed
    always_comb begin
        case (r_slot)
            2'd0:    w_count = r_vcnt;
            2'd1:    w_count = r_tcnt;
            default: w_count = r_ncnt;
        endcase
    end

    always_comb begin
        if (!r_neg || r_accum == '0) begin
            w_res = r_accum;
        end else if (r_accum > w_count) begin
            w_res = '0;
        end else begin
            w_res = w_count - r_accum + INDEX_BITS'(1);
        end
    end

    assign w_wide = {4'b0, r_accum} * WIDE_W'(10) + WIDE_W'(i_text_byte - CH_0);

    assign w_cv   = (r_slot == 2'd0) ? w_res : r_held_v;
    assign w_ct   = (r_slot == 2'd1) ? w_res : r_held_t;
    assign w_cn   = (r_slot == 2'd2) ? w_res : '0;
    assign w_keep = (w_cv != '0);

    // A face body token closes on a blank or on the newline
    assign w_close = i_fire && r_tok && (r_kind == K_F) && (r_pend == P_DONE)
                     && (w_nl || w_blank);
    assign w_end   = i_fire && w_nl && (r_kind == K_F);

    // Next state
    always_comb begin
        n_kind   = r_kind;
        n_pend   = r_pend;
        n_ph     = r_ph;
        n_neg    = r_neg;
        n_tok    = r_tok;
        n_slot   = r_slot;
        n_accum  = r_accum;
        n_held_v = r_held_v;
        n_held_t = r_held_t;
        n_vcnt   = r_vcnt;
        n_tcnt   = r_tcnt;
        n_ncnt   = r_ncnt;
        n_face   = r_face;
        if (i_fire) begin
            if (w_nl) begin
                if (r_kind == K_V && r_vcnt != IDX_MAX) begin
                    n_vcnt = r_vcnt + INDEX_BITS'(1);
                end
                if (r_kind == K_VT && r_tcnt != IDX_MAX) begin
                    n_tcnt = r_tcnt + INDEX_BITS'(1);
                end
                if (r_kind == K_VN && r_ncnt != IDX_MAX) begin
                    n_ncnt = r_ncnt + INDEX_BITS'(1);
                end
                if (r_kind == K_F && r_face != IDX_MAX) begin
                    n_face = r_face + INDEX_BITS'(1);
                end
                n_kind   = K_NONE;
                n_pend   = P_START;
                n_tok    = 1'b0;
                n_slot   = 2'd0;
                n_held_v = '0;
                n_held_t = '0;
                n_accum  = '0;
                n_ph     = PH_START;
                n_neg    = 1'b0;
            end else begin
                case (r_pend)
                    P_START: begin
                        if (!w_blank) begin
                            n_pend = P_DONE;
                            if (i_text_byte == CH_HASH) begin
                                n_kind = K_COMMENT;
                            end else if (i_text_byte == CH_V) begin
                                n_pend = P_AFTER_V;
                            end else if (i_text_byte == CH_F) begin
                                n_pend = P_AFTER_F;
                            end else begin
                                n_kind = K_OTHER;
                            end
                        end
                    end
                    P_AFTER_V: begin
                        n_pend = P_DONE;
                        if (i_text_byte == CH_T) begin
                            n_kind = K_VT;
                        end else if (i_text_byte == CH_N) begin
                            n_kind = K_VN;
                        end else if (w_blank) begin
                            n_kind = K_V;
                        end else begin
                            n_kind = K_OTHER;
                        end
                    end
                    P_AFTER_F: begin
                        n_pend = P_DONE;
                        n_kind = w_blank ? K_F : K_OTHER;
                    end
                    default: begin
                        if (r_kind == K_F) begin
                            if (w_blank) begin
                                // closed token leaves slot, number and held refs clear
                                n_tok    = 1'b0;
                                n_slot   = 2'd0;
                                n_held_v = '0;
                                n_held_t = '0;
                                n_accum  = '0;
                                n_ph     = PH_START;
                                n_neg    = 1'b0;
                            end else begin
                                n_tok = 1'b1;
                                if (i_text_byte == CH_SLASH && r_slot < 2'd2) begin
                                    if (r_slot == 2'd0) begin
                                        n_held_v = w_res;
                                    end else begin
                                        n_held_t = w_res;
                                    end
                                    n_slot  = r_slot + 2'd1;
                                    n_accum = '0;
                                    n_ph    = PH_START;
                                    n_neg   = 1'b0;
                                end else if (r_ph != PH_STOP) begin
                                    if (w_digit) begin
                                        n_accum = (w_wide > WIDE_W'(IDX_MAX)) ? IDX_MAX
                                                : w_wide[INDEX_BITS-1:0];
                                        n_ph    = PH_DIGITS;
                                    end else if (r_ph == PH_START && w_sign) begin
                                        n_neg = (i_text_byte == CH_MINUS);
                                        n_ph  = PH_DIGITS;
                                    end else begin
                                        n_ph = PH_STOP;
                                    end
                                end
                            end
                        end
                    end
                endcase
            end
        end
    end

    // Event out to the queue
    always_comb begin
        o_push.push            = (w_close && w_keep) || w_end;
        o_push.data.has_corner = w_close && w_keep;
        o_push.data.is_end     = w_end;
        o_push.data.face       = OUT_W'(r_face);
        o_push.data.vref       = OUT_W'(w_cv);
        o_push.data.tref       = OUT_W'(w_ct);
        o_push.data.nref       = OUT_W'(w_cn);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind   <= K_NONE;
            r_pend   <= P_START;
            r_ph     <= PH_START;
            r_neg    <= 1'b0;
            r_tok    <= 1'b0;
            r_slot   <= 2'd0;
            r_accum  <= '0;
            r_held_v <= '0;
            r_held_t <= '0;
            r_vcnt   <= '0;
            r_tcnt   <= '0;
            r_ncnt   <= '0;
            r_face   <= '0;
        end else begin
            r_kind   <= n_kind;
            r_pend   <= n_pend;
            r_ph     <= n_ph;
            r_neg    <= n_neg;
            r_tok    <= n_tok;
            r_slot   <= n_slot;
            r_accum  <= n_accum;
            r_held_v <= n_held_v;
            r_held_t <= n_held_t;
            r_vcnt   <= n_vcnt;
            r_tcnt   <= n_tcnt;
            r_ncnt   <= n_ncnt;
            r_face   <= n_face;
        end
    end

endmodule

[hw/rtl/ofsp_queue.sv]
module ofsp_queue
    import ofsp_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_push  i_push,
    input  logic   i_pop,
    output t_event o_data,
    output logic   o_not_empty,
    output logic   o_full
);

    t_event            r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, n_wr;
    logic [QPTR_W-1:0] r_rd, n_rd;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              w_wen, w_ren;

    assign o_full      = (r_cnt == QCNT_W'(QDEPTH));
    assign o_not_empty = (r_cnt != '0);
    assign o_data      = r_mem[r_rd];

    assign w_wen = i_push.push && !o_full;
    assign w_ren = i_pop && o_not_empty;

    always_comb begin
        n_wr  = w_wen ? r_wr + QPTR_W'(1) : r_wr;
        n_rd  = w_ren ? r_rd + QPTR_W'(1) : r_rd;
        n_cnt = r_cnt + QCNT_W'(w_wen) - QCNT_W'(w_ren);
    end

    always_ff @(posedge i_clk) begin
        if (w_wen) begin
            r_mem[r_wr] <= i_push.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

[hw/rtl/ofsp_back.sv]
module ofsp_back
    import ofsp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_event           i_data,
    input  logic             i_not_empty,
    output logic             o_pop,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic             o_record_kind,
    output logic [OUT_W-1:0] o_face_number,
    output logic [OUT_W-1:0] o_vertex_ref,
    output logic [OUT_W-1:0] o_texcoord_ref,
    output logic [OUT_W-1:0] o_normal_ref
);

    logic             r_valid, n_valid;
    logic             r_end_pend, n_end_pend;
    logic [OUT_W-1:0] r_end_face, n_end_face;
    logic             r_kind, n_kind;
    logic [OUT_W-1:0] r_face, n_face;
    logic [OUT_W-1:0] r_v, n_v;
    logic [OUT_W-1:0] r_t, n_t;
    logic [OUT_W-1:0] r_n, n_n;
    logic             w_load;

    // Output register frees up when empty or its beat is taken
    assign w_load = !r_valid || i_out_ready;
    assign o_pop  = w_load && !r_end_pend && i_not_empty;

    always_comb begin
        n_valid    = r_valid;
        n_end_pend = r_end_pend;
        n_end_face = r_end_face;
        n_kind     = r_kind;
        n_face     = r_face;
        n_v        = r_v;
        n_t        = r_t;
        n_n        = r_n;
        if (w_load) begin
            if (r_end_pend) begin
                // marker left over from an event that also carried a corner
                n_valid    = 1'b1;
                n_end_pend = 1'b0;
                n_kind     = REC_END;
                n_face     = r_end_face;
                n_v        = '0;
                n_t        = '0;
                n_n        = '0;
            end else if (i_not_empty) begin
                n_valid = 1'b1;
                n_face  = i_data.face;
                if (i_data.has_corner) begin
                    n_kind     = REC_CORNER;
                    n_v        = i_data.vref;
                    n_t        = i_data.tref;
                    n_n        = i_data.nref;
                    n_end_pend = i_data.is_end;
                    n_end_face = i_data.face;
                end else begin
                    n_kind = REC_END;
                    n_v    = '0;
                    n_t    = '0;
                    n_n    = '0;
                end
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_end_pend <= 1'b0;
        end else begin
            r_valid    <= n_valid;
            r_end_pend <= n_end_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_end_face <= n_end_face;
        r_kind     <= n_kind;
        r_face     <= n_face;
        r_v        <= n_v;
        r_t        <= n_t;
        r_n        <= n_n;
    end

    assign o_out_valid    = r_valid;
    assign o_record_kind  = r_kind;
    assign o_face_number  = r_face;
    assign o_vertex_ref   = r_v;
    assign o_texcoord_ref = r_t;
    assign o_normal_ref   = r_n;

endmodule

[hw/rtl/obj_face_stream_parser_unit.sv]
// Channel  | valid        | ready        | payload
// ---------+--------------+--------------+----------------------------------------------
// text in  | i_in_valid   | o_in_ready   | i_text_byte
// records  | o_out_valid  | i_out_ready  | o_record_kind, o_face_number, o_vertex_ref,
//          |              |              | o_texcoord_ref, o_normal_ref
//
// One text byte per cycle; the front decodes each byte in the cycle it is taken.
// A byte's event is written into the queue, then loaded into the output register, before it reaches the record port.
// A newline that closes a corner with a nonzero vertex reference yields two records: the corner, then the face end.
// Bytes stall only when the four-entry event queue is full.
// Synchronous active-low reset clears counters and line state; no clearing pass.
module obj_face_stream_parser_unit
    import ofsp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [7:0]       i_text_byte,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic             o_record_kind,
    output logic [OUT_W-1:0] o_face_number,
    output logic [OUT_W-1:0] o_vertex_ref,
    output logic [OUT_W-1:0] o_texcoord_ref,
    output logic [OUT_W-1:0] o_normal_ref
);

    t_push  w_push;
    t_event w_qdata;
    logic   w_full, w_not_empty, w_pop, w_fire;

    assign o_in_ready = !w_full;
    assign w_fire     = i_in_valid && o_in_ready;

    ofsp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_fire),
        .i_text_byte (i_text_byte),
        .o_push      (w_push)
    );

    ofsp_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_pop       (w_pop),
        .o_data      (w_qdata),
        .o_not_empty (w_not_empty),
        .o_full      (w_full)
    );

    ofsp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_data         (w_qdata),
        .i_not_empty    (w_not_empty),
        .o_pop          (w_pop),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_record_kind  (o_record_kind),
        .o_face_number  (o_face_number),
        .o_vertex_ref   (o_vertex_ref),
        .o_texcoord_ref (o_texcoord_ref),
        .o_normal_ref   (o_normal_ref)
    );

endmodule

[hw/rtl/ofsp_checker.sv]
module ofsp_checker
    import ofsp_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_ready,
    input logic [7:0]       i_text_byte,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input logic             o_record_kind,
    input logic [OUT_W-1:0] o_face_number,
    input logic [OUT_W-1:0] o_vertex_ref,
    input logic [OUT_W-1:0] o_texcoord_ref,
    input logic [OUT_W-1:0] o_normal_ref
);

    // stalled record beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_record_kind)
            && $stable(o_face_number) && $stable(o_vertex_ref)
            && $stable(o_texcoord_ref) && $stable(o_normal_ref))
        else $error("record beat changed while stalled");

    a_end_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_record_kind == REC_END |->
            o_vertex_ref == '0 && o_texcoord_ref == '0 && o_normal_ref == '0)
        else $error("face-end marker carries references");

    // dropped corners never reach the port
    a_corner_vert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_record_kind == REC_CORNER |-> o_vertex_ref != '0)
        else $error("corner without vertex reference");

    // an end marker taken is not followed at once by a corner of the same face
    a_face_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_record_kind == REC_END
            && o_face_number != {OUT_W{1'b1}}
            ##1 o_out_valid && o_record_kind == REC_CORNER
        |-> o_face_number != $past(o_face_number))
        else $error("corner after face end kept the old face number");

endmodule

bind obj_face_stream_parser_unit ofsp_checker u_ofsp_checker (.*);
